// ===== src/efe_pkg.sv =====
// ============================================================================
// efe_pkg
// Shared types and constants of the escaped frame encoder: queue entry
// layout, configuration bundle, sequencer step codes and register indexes.
// ============================================================================
package efe_pkg;

    localparam int BYTE_W      = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int S_TDATA_W   = 40;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 2;
    localparam int CFG_IDX_W   = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    // Input item kinds
    localparam logic MODE_HEADER  = 1'b0;
    localparam logic MODE_PAYLOAD = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BEGIN_VALUE   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_VALUE  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDRESS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD_ADDRESS = 8'd3;

    // Configuration reset values
    localparam byte_t RST_BEGIN_VALUE   = 8'd224;
    localparam byte_t RST_ESCAPE_VALUE  = 8'd208;
    localparam byte_t RST_HOST_ADDRESS  = 8'd1;
    localparam byte_t RST_BOARD_ADDRESS = 8'd2;

    // Length byte carries payload length plus the three trailing header bytes
    localparam byte_t LEN_BIAS = 8'd3;
    localparam byte_t ESC_DEC  = 8'd1;

    // Sequencer steps over the wire bytes of one queued request
    typedef logic [2:0] step_t;
    localparam step_t STEP_BEGIN   = 3'd0;
    localparam step_t STEP_HOST    = 3'd1;
    localparam step_t STEP_BOARD   = 3'd2;
    localparam step_t STEP_LENGTH  = 3'd3;
    localparam step_t STEP_STATUS  = 3'd4;
    localparam step_t STEP_COMMAND = 3'd5;
    localparam step_t STEP_TAIL    = 3'd6;  // report on a header, data on a payload
    localparam step_t STEP_SUM     = 3'd7;

    typedef struct packed {
        logic  is_header;
        logic  port;
        logic  close;
        byte_t length;
        byte_t status;
        byte_t command;
        byte_t tail;
    } entry_t;

    typedef struct packed {
        byte_t begin_value;
        byte_t escape_value;
        byte_t host_address;
        byte_t board_address;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ===== src/escaped_frame_encoder_core.sv =====
// ============================================================================
// escaped_frame_encoder_core
// Byte-stuffed response frame encoder with an 8-bit wrapping checksum.
// ============================================================================
//
//   channel  direction  handshake            contents
//   s_       in         s_tvalid/s_tready    header or payload item
//   m_       out        m_tvalid/m_tready    one wire byte per transfer
//   cfg_     in         cfg_valid/cfg_ready  register index and write data
//
// A header item gives 7 to 15 wire bytes, a payload item 1 to 4, escaped
// bytes taking two; the back sequencer emits one wire byte per cycle unless m_tready stalls it.
// A two-entry request queue lets the front accept items while the back works.
// Reset is synchronous, active low; it closes any frame and restores the
// default register values. A stalled m_tready holds the output register and,
// once the queue fills, s_tready drops. Configuration writes are always taken.
module escaped_frame_encoder_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // payload_length, status_code, command_code, report_code, data_byte
    input  logic [efe_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode, port
    input  logic [efe_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_byte
    output logic [efe_pkg::BYTE_W-1:0]      m_tdata,
    // frame_end
    output logic                            m_tlast,
    // out_port, run_last
    output logic [efe_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [efe_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efe_pkg::BYTE_W-1:0]      cfg_data
);

    efe_pkg::cfg_t      cfg_reg, cfg_next;
    efe_pkg::q_status_t q_status;
    efe_pkg::entry_t    push_entry;
    efe_pkg::entry_t    head;
    logic               push;
    logic               pop;

    assign cfg_ready = 1'b1;

    // Decode register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                efe_pkg::CFG_BEGIN_VALUE:   cfg_next.begin_value   = cfg_data;
                efe_pkg::CFG_ESCAPE_VALUE:  cfg_next.escape_value  = cfg_data;
                efe_pkg::CFG_HOST_ADDRESS:  cfg_next.host_address  = cfg_data;
                efe_pkg::CFG_BOARD_ADDRESS: cfg_next.board_address = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.begin_value   <= efe_pkg::RST_BEGIN_VALUE;
            cfg_reg.escape_value  <= efe_pkg::RST_ESCAPE_VALUE;
            cfg_reg.host_address  <= efe_pkg::RST_HOST_ADDRESS;
            cfg_reg.board_address <= efe_pkg::RST_BOARD_ADDRESS;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    efe_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    efe_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .q_status   (q_status)
    );

    efe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // The checksum byte always closes the run of its item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> m_tuser[1])
        else $error("frame end without run end");

    // Never write into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !q_status.full)
        else $error("request queue overflow");

    // Never pop an empty queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("request queue underflow");

    // Output is empty right after a reset cycle
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== src/efe_front.sv =====
// ============================================================================
// efe_front
// Accepts input items, tracks the open frame and queues classified requests.
// ============================================================================
module efe_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // payload_length, status_code, command_code, report_code, data_byte
    input  logic [efe_pkg::S_TDATA_W-1:0]   s_tdata,
    // mode, port
    input  logic [efe_pkg::S_TUSER_W-1:0]   s_tuser,
    input  efe_pkg::q_status_t              q_status,
    output logic                            push,
    output efe_pkg::entry_t                 push_entry
);

    logic          in_frame_reg, in_frame_next;
    efe_pkg::byte_t bytes_left_reg, bytes_left_next;
    logic          port_reg, port_next;

    logic           accept;
    logic           mode;
    efe_pkg::byte_t len_in;
    efe_pkg::byte_t left_dec;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[0];
    assign len_in   = s_tdata[7:0];
    assign left_dec = bytes_left_reg - efe_pkg::byte_t'(1);

    // Classify the item and update the frame tracking
    always_comb begin
        in_frame_next   = in_frame_reg;
        bytes_left_next = bytes_left_reg;
        port_next       = port_reg;
        push            = 1'b0;
        push_entry.is_header = (mode == efe_pkg::MODE_HEADER);
        push_entry.port      = port_reg;
        push_entry.close     = 1'b0;
        push_entry.length    = len_in;
        push_entry.status    = s_tdata[15:8];
        push_entry.command   = s_tdata[23:16];
        push_entry.tail      = s_tdata[31:24];
        if (accept) begin
            unique case (mode)
                efe_pkg::MODE_HEADER: begin
                    push             = 1'b1;
                    push_entry.port  = s_tuser[1];
                    push_entry.close = (len_in == '0);
                    port_next        = s_tuser[1];
                    bytes_left_next  = len_in;
                    in_frame_next    = (len_in != '0);
                end
                efe_pkg::MODE_PAYLOAD: begin
                    // drop payload bytes outside a frame
                    if (in_frame_reg) begin
                        push             = 1'b1;
                        push_entry.tail  = s_tdata[39:32];
                        push_entry.close = (left_dec == '0);
                        bytes_left_next  = left_dec;
                        in_frame_next    = (left_dec != '0);
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= '0;
            port_reg       <= 1'b0;
        end else begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
            port_reg       <= port_next;
        end
    end

endmodule

// ===== src/efe_queue.sv =====
// ============================================================================
// efe_queue
// Short request queue between the front and the back.
// ============================================================================
module efe_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  efe_pkg::entry_t    push_entry,
    input  logic               pop,
    output efe_pkg::entry_t    head,
    output efe_pkg::q_status_t q_status
);

    efe_pkg::entry_t                entry_reg [efe_pkg::QUEUE_DEPTH];
    logic [efe_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [efe_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [efe_pkg::QCNT_W-1:0]     count_reg, count_next;

    assign head           = entry_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == efe_pkg::QCNT_W'(efe_pkg::QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);

    function automatic logic [efe_pkg::QPTR_W-1:0] ptr_inc(
        input logic [efe_pkg::QPTR_W-1:0] p
    );
        if (p == efe_pkg::QPTR_W'(efe_pkg::QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + efe_pkg::QPTR_W'(1);
    endfunction

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + efe_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - efe_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== src/efe_back.sv =====
// ============================================================================
// efe_back
// Walks each queued request byte by byte, escapes special bytes, keeps the
// running checksum and drives the registered output stream.
// ============================================================================
module efe_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  efe_pkg::cfg_t                 cfg,
    input  efe_pkg::entry_t               head,
    input  efe_pkg::q_status_t            q_status,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_byte
    output logic [efe_pkg::BYTE_W-1:0]    m_tdata,
    // frame_end
    output logic                          m_tlast,
    // out_port, run_last
    output logic [efe_pkg::M_TUSER_W-1:0] m_tuser
);

    efe_pkg::step_t step_reg, step_next;
    logic           fresh_reg, fresh_next;
    logic           esc_reg, esc_next;
    efe_pkg::byte_t sum_reg, sum_next;

    logic           out_valid_reg, out_valid_next;
    efe_pkg::byte_t out_byte_reg, out_byte_next;
    logic           out_port_reg, out_port_next;
    logic           out_end_reg, out_end_next;
    logic           out_last_reg, out_last_next;

    efe_pkg::step_t start_step, cur_step, end_step;
    efe_pkg::byte_t cur_val;
    logic           special;
    logic           load, go;

    assign start_step = head.is_header ? efe_pkg::STEP_BEGIN : efe_pkg::STEP_TAIL;
    assign end_step   = head.close ? efe_pkg::STEP_SUM : efe_pkg::STEP_TAIL;
    assign cur_step   = fresh_reg ? start_step : step_reg;
    assign load       = !out_valid_reg || m_tready;
    assign go         = load && !q_status.empty;

    // Pick the unescaped byte for this step
    always_comb begin
        unique case (cur_step)
            efe_pkg::STEP_BEGIN:   cur_val = cfg.begin_value;
            efe_pkg::STEP_HOST:    cur_val = cfg.host_address;
            efe_pkg::STEP_BOARD:   cur_val = cfg.board_address;
            efe_pkg::STEP_LENGTH:  cur_val = head.length + efe_pkg::LEN_BIAS;
            efe_pkg::STEP_STATUS:  cur_val = head.status;
            efe_pkg::STEP_COMMAND: cur_val = head.command;
            efe_pkg::STEP_TAIL:    cur_val = head.tail;
            efe_pkg::STEP_SUM:     cur_val = sum_reg;
            default:               cur_val = '0;
        endcase
    end

    assign special = (cur_step != efe_pkg::STEP_BEGIN) &&
                     ((cur_val == cfg.begin_value) || (cur_val == cfg.escape_value));

    // Sequence one wire byte per cycle into the output register while it can load and a request waits
    always_comb begin
        step_next      = step_reg;
        fresh_next     = fresh_reg;
        esc_next       = esc_reg;
        sum_next       = sum_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_port_next  = out_port_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        if (load) begin
            out_valid_next = go;
        end
        if (go) begin
            out_port_next = head.port;
            out_end_next  = 1'b0;
            out_last_next = 1'b0;
            if (special && !esc_reg) begin
                // send the marker first, hold the step
                out_byte_next = cfg.escape_value;
                esc_next      = 1'b1;
                step_next     = cur_step;
                fresh_next    = 1'b0;
            end else begin
                out_byte_next = esc_reg ? (cur_val - efe_pkg::ESC_DEC) : cur_val;
                esc_next      = 1'b0;
                if ((cur_step == efe_pkg::STEP_BEGIN) || (cur_step == efe_pkg::STEP_SUM)) begin
                    sum_next = '0;
                end else begin
                    sum_next = sum_reg + cur_val;
                end
                out_end_next = (cur_step == efe_pkg::STEP_SUM);
                if (cur_step == end_step) begin
                    pop           = 1'b1;
                    fresh_next    = 1'b1;
                    out_last_next = 1'b1;
                end else begin
                    step_next  = cur_step + efe_pkg::step_t'(1);
                    fresh_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= efe_pkg::STEP_BEGIN;
            fresh_reg     <= 1'b1;
            esc_reg       <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            step_reg      <= step_next;
            fresh_reg     <= fresh_next;
            esc_reg       <= esc_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_byte_reg <= out_byte_next;
        out_port_reg <= out_port_next;
        out_end_reg  <= out_end_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_end_reg;
    assign m_tuser  = {out_last_reg, out_port_reg};

endmodule

// ===== dv/escaped_frame_encoder_core_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// escaped_frame_encoder_core_tb
// Self-checking bench for the escaped frame encoder. A clocked driver pushes
// header and payload requests in random bursts. A clocked monitor stalls the
// byte stream on a pattern of its own and checks every wire byte against a
// frame encoder written here. The run goes through several register settings,
// and each one is written while the block is idle.
// ============================================================================
module escaped_frame_encoder_core_tb;

    localparam int LIMIT_CYCLES = 400000;
    localparam int SETTLE_CYCLES = 32;

    typedef struct packed {
        logic           mode;
        logic           port;
        efe_pkg::byte_t length;
        efe_pkg::byte_t status;
        efe_pkg::byte_t command;
        efe_pkg::byte_t report;
        efe_pkg::byte_t data;
    } frame_item_t;

    typedef struct packed {
        efe_pkg::byte_t data;
        logic           port;
        logic           frame_end;
        logic           run_last;
    } tx_byte_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [efe_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [efe_pkg::S_TUSER_W-1:0] s_tuser = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [efe_pkg::BYTE_W-1:0]    m_tdata;
    logic                          m_tlast;
    logic [efe_pkg::M_TUSER_W-1:0] m_tuser;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [efe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [efe_pkg::BYTE_W-1:0]    cfg_data = '0;

    escaped_frame_encoder_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Encoder mirror: registers and frame state
    efe_pkg::cfg_t  enc_cfg = '{begin_value:   efe_pkg::RST_BEGIN_VALUE,
                                escape_value:  efe_pkg::RST_ESCAPE_VALUE,
                                host_address:  efe_pkg::RST_HOST_ADDRESS,
                                board_address: efe_pkg::RST_BOARD_ADDRESS};
    efe_pkg::byte_t enc_sum = '0;
    efe_pkg::byte_t enc_left = '0;
    logic           enc_port = 1'b0;
    logic           enc_open = 1'b0;
    tx_byte_t       run_bytes [16];
    int             run_n;
    tx_byte_t       expected_bytes [$];

    frame_item_t    pending_items [$];
    frame_item_t    drv_cur;
    int             burst_left = 0;
    int             gap_left = 0;

    // Stimulus plan: values the generator aims at in the current setting
    efe_pkg::byte_t plan_begin = efe_pkg::RST_BEGIN_VALUE;
    efe_pkg::byte_t plan_escape = efe_pkg::RST_ESCAPE_VALUE;
    logic           gen_open = 1'b0;

    int             errors = 0;
    int             cycles = 0;
    int             rx_cyc = 0;
    int             rx_mode = 0;
    tx_byte_t       want;

    function automatic void put_raw(efe_pkg::byte_t b);
        tx_byte_t t;
        t.data = b;
        t.port = enc_port;
        t.frame_end = 1'b0;
        t.run_last = 1'b0;
        run_bytes[run_n] = t;
        run_n++;
    endfunction

    function automatic void put_escaped(efe_pkg::byte_t b);
        efe_pkg::byte_t v;
        v = b;
        if (v == enc_cfg.begin_value || v == enc_cfg.escape_value) begin
            put_raw(enc_cfg.escape_value);
            v = v - efe_pkg::ESC_DEC;
        end
        put_raw(v);
    endfunction

    function automatic void put_summed(efe_pkg::byte_t b);
        enc_sum = enc_sum + b;
        put_escaped(b);
    endfunction

    function automatic void close_frame();
        put_escaped(enc_sum);
        run_bytes[run_n-1].frame_end = 1'b1;
        enc_open = 1'b0;
        enc_sum = '0;
        enc_left = '0;
    endfunction

    // Work out the wire bytes one accepted request causes
    function automatic void encode_request(frame_item_t it);
        run_n = 0;
        if (it.mode == efe_pkg::MODE_HEADER) begin
            enc_port = it.port;
            enc_sum = '0;
            enc_open = 1'b1;
            enc_left = it.length;
            put_raw(enc_cfg.begin_value);
            put_summed(enc_cfg.host_address);
            put_summed(enc_cfg.board_address);
            put_summed(efe_pkg::byte_t'(it.length + efe_pkg::LEN_BIAS));
            put_summed(it.status);
            put_summed(it.command);
            put_summed(it.report);
            if (it.length == 0)
                close_frame();
        end else if (enc_open) begin
            put_summed(it.data);
            enc_left = enc_left - 8'd1;
            if (enc_left == 0)
                close_frame();
        end
        if (run_n > 0)
            run_bytes[run_n-1].run_last = 1'b1;
        for (int i = 0; i < run_n; i++)
            expected_bytes.push_back(run_bytes[i]);
    endfunction

    function automatic frame_item_t hdr_item(logic port, efe_pkg::byte_t len,
                                             efe_pkg::byte_t st, efe_pkg::byte_t cmd,
                                             efe_pkg::byte_t rep);
        frame_item_t it;
        it.mode = efe_pkg::MODE_HEADER;
        it.port = port;
        it.length = len;
        it.status = st;
        it.command = cmd;
        it.report = rep;
        it.data = efe_pkg::byte_t'($urandom_range(0, 255));
        return it;
    endfunction

    function automatic frame_item_t pay_item(efe_pkg::byte_t d);
        frame_item_t it;
        it.mode = efe_pkg::MODE_PAYLOAD;
        it.port = 1'($urandom_range(0, 1));
        it.length = efe_pkg::byte_t'($urandom_range(0, 255));
        it.status = efe_pkg::byte_t'($urandom_range(0, 255));
        it.command = efe_pkg::byte_t'($urandom_range(0, 255));
        it.report = efe_pkg::byte_t'($urandom_range(0, 255));
        it.data = d;
        return it;
    endfunction

    // Lean toward the special bytes of the current setting
    function automatic efe_pkg::byte_t pick_byte();
        case ($urandom_range(0, 11))
            0: return plan_begin;
            1: return plan_escape;
            2: return plan_begin + 8'd1;
            3: return plan_escape + 8'd1;
            4: return 8'd0;
            5: return 8'd255;
            default: return efe_pkg::byte_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Driver: hold each request until taken, work in bursts with gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                encode_request(drv_cur);
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || pending_items.size() == 0) begin
                    if (gap_left > 0)
                        gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    drv_cur = pending_items.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {drv_cur.data, drv_cur.report, drv_cur.command,
                                drv_cur.status, drv_cur.length};
                    s_tuser <= {drv_cur.port, drv_cur.mode};
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Monitor: stall on a changing pattern, check each accepted byte
    always @(posedge aclk) begin
        rx_cyc++;
        if (rx_cyc % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cyc % 4 == 0);
            default: m_tready <= (rx_cyc % 16 < 3);
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_bytes.size() == 0) begin
                $error("unexpected result: out_byte %0h", m_tdata);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte: expected %0h, actual %0h", want.data, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.port) begin
                    $error("out_port: expected %0b, actual %0b", want.port, m_tuser[0]);
                    errors++;
                end
                if (m_tlast !== want.frame_end) begin
                    $error("frame_end: expected %0b, actual %0b", want.frame_end, m_tlast);
                    errors++;
                end
                if (m_tuser[1] !== want.run_last) begin
                    $error("run_last: expected %0b, actual %0b", want.run_last, m_tuser[1]);
                    errors++;
                end
            end
        end
    end

    // Track register writes into the mirror
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            case (cfg_index)
                efe_pkg::CFG_BEGIN_VALUE:   enc_cfg.begin_value = cfg_data;
                efe_pkg::CFG_ESCAPE_VALUE:  enc_cfg.escape_value = cfg_data;
                efe_pkg::CFG_HOST_ADDRESS:  enc_cfg.host_address = cfg_data;
                efe_pkg::CFG_BOARD_ADDRESS: enc_cfg.board_address = cfg_data;
                default: ;
            endcase
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [efe_pkg::CFG_IDX_W-1:0] idx,
                             input efe_pkg::byte_t val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input efe_pkg::byte_t bv, input efe_pkg::byte_t ev,
                              input efe_pkg::byte_t ha, input efe_pkg::byte_t ba);
        write_reg(efe_pkg::CFG_BEGIN_VALUE, bv);
        write_reg(efe_pkg::CFG_ESCAPE_VALUE, ev);
        write_reg(efe_pkg::CFG_HOST_ADDRESS, ha);
        write_reg(efe_pkg::CFG_BOARD_ADDRESS, ba);
        plan_begin = bv;
        plan_escape = ev;
    endtask

    // Wait until every request is taken and every byte has come out
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly whole frames; some cut short by the next header, some strays
    task automatic queue_random_frames(input int target);
        int made;
        int len;
        int cnt;
        int kind;
        made = 0;
        while (made < target) begin
            kind = $urandom_range(0, 9);
            if (kind == 0 && !gen_open) begin
                pending_items.push_back(pay_item(pick_byte()));
            end else if (kind == 1) begin
                len = $urandom_range(1, 255);
                cnt = $urandom_range(0, (len > 6) ? 5 : len - 1);
                pending_items.push_back(hdr_item(1'($urandom_range(0, 1)),
                                                 efe_pkg::byte_t'(len),
                                                 pick_byte(), pick_byte(), pick_byte()));
                for (int i = 0; i < cnt; i++)
                    pending_items.push_back(pay_item(pick_byte()));
                made += cnt + 1;
                gen_open = 1'b1;
            end else begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40)
                                                   : $urandom_range(0, 6);
                pending_items.push_back(hdr_item(1'($urandom_range(0, 1)),
                                                 efe_pkg::byte_t'(len),
                                                 pick_byte(), pick_byte(), pick_byte()));
                for (int i = 0; i < len; i++)
                    pending_items.push_back(pay_item(pick_byte()));
                made += len + 1;
                gen_open = 1'b0;
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset values: strays, empty payload, special bytes, abandoned frames
        pending_items.push_back(pay_item(8'hE0));
        pending_items.push_back(hdr_item(1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
        pending_items.push_back(hdr_item(1'b1, 8'd2, 8'd224, 8'd208, 8'd255));
        pending_items.push_back(pay_item(8'd224));
        pending_items.push_back(pay_item(8'd208));
        pending_items.push_back(hdr_item(1'b1, 8'd255, 8'd255, 8'd255, 8'd255));
        pending_items.push_back(pay_item(8'd0));
        pending_items.push_back(pay_item(8'd255));
        pending_items.push_back(hdr_item(1'b0, 8'd253, 8'd209, 8'd225, 8'd1));
        pending_items.push_back(hdr_item(1'b0, 8'd1, 8'd128, 8'd64, 8'd32));
        pending_items.push_back(pay_item(8'h5A));
        pending_items.push_back(pay_item(8'd7));
        drain();

        // Extreme setting: a zero begin byte escapes to 255
        set_config(8'd0, 8'd255, 8'd0, 8'd255);
        pending_items.push_back(hdr_item(1'b1, 8'd0, 8'd0, 8'd255, 8'd1));
        pending_items.push_back(hdr_item(1'b0, 8'd3, 8'd254, 8'd1, 8'd128));
        pending_items.push_back(pay_item(8'd0));
        pending_items.push_back(pay_item(8'd255));
        pending_items.push_back(pay_item(8'd1));
        pending_items.push_back(pay_item(8'd0));
        drain();

        set_config(efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)));
        queue_random_frames(40);
        drain();

        set_config(8'd255, 8'd0, 8'd255, 8'd0);
        queue_random_frames(40);
        drain();

        // Begin and escape share one value
        set_config(8'h7E, 8'h7E, efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)));
        queue_random_frames(40);
        drain();

        set_config(efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)),
                   efe_pkg::byte_t'($urandom_range(0, 255)));
        queue_random_frames(40);
        drain();

        set_config(efe_pkg::RST_BEGIN_VALUE, efe_pkg::RST_ESCAPE_VALUE,
                   efe_pkg::RST_HOST_ADDRESS, efe_pkg::RST_BOARD_ADDRESS);
        queue_random_frames(40);
        drain();

        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/efe_pkg.sv
src/efe_front.sv
src/efe_queue.sv
src/efe_back.sv
src/escaped_frame_encoder_core.sv
dv/escaped_frame_encoder_core_tb.sv
